### sv/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

	// store geometry
	localparam int CAPACITY   = 256;
	localparam int ITEM_WIDTH = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// read reduction tree: groups of cells or-ed in the first stage
	localparam int GRP  = 16;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_SET    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [7:0]  index;
		logic [31:0] item_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [7:0]  new_index;
		logic [8:0]  entry_count;
		status_t     status;
	} rsp_t;

	// command broadcast to every cell of the row
	typedef enum logic [1:0] {
		CELL_NOP   = 2'd0,
		CELL_WRITE = 2'd1,
		CELL_SHIFT = 2'd2,
		CELL_READ  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     pos;
		cnt_t     last;
		item_t    data;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_RD   = 2'd2,
		S_DONE = 2'd3
	} state_t;

endpackage

`default_nettype wire

### sv/ils_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_cell import ils_pkg::*; (
	input  wire logic      clk,
	input  wire cell_cmd_t cmd,
	input  wire idx_t      pos,
	input  wire item_t     nbr,
	output item_t          data,
	output item_t          rd
);

	item_t data_q;
	logic  hit;
	logic  in_shift;

	// position match and shift window [cmd.pos, cmd.last)
	always_comb begin
		hit      = (cmd.pos == pos);
		in_shift = (pos >= cmd.pos) && (cnt_t'(pos) < cmd.last);
	end

	// entry register: write own slot, or take the upper neighbor on remove
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_WRITE: begin
				if (hit) begin
					data_q <= cmd.data;
				end
			end
			CELL_SHIFT: begin
				if (in_shift) begin
					data_q <= nbr;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	// masked read onto the reduction tree
	assign rd   = ((cmd.op == CELL_READ) && hit) ? data_q : '0;
	assign data = data_q;

endmodule

`default_nettype wire

### sv/ils_rd_tree.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_rd_tree import ils_pkg::*; (
	input  wire logic  clk,
	input  wire item_t words [CAPACITY],
	input  wire logic  en_s1,
	input  wire logic  en_s2,
	output item_t      rd
);

	item_t grp_or [NGRP];
	item_t rd_s1  [NGRP];
	item_t top_or;
	item_t rd_s2;

	// first level: or across each group of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					grp_or[g] = grp_or[g] | words[g * GRP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rd_s1 <= grp_or;
		end
	end

	// second level: or across the group results
	always_comb begin
		top_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			top_or = top_or | rd_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rd_s2 <= top_or;
		end
	end

	assign rd = rd_s2;

endmodule

`default_nettype wire

### sv/indexed_list_store_unit.sv
// indexed list store: a compact ordered list of up to CAPACITY entries.
// request channel (req_valid, req_stall, req): one beat per request, the
// kind being append, remove at index, get at index or set at index.
// response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// carrying the read value, the append position, the entry count after the
// request and a status (ok, index out of range, store full).
// entries live in a row of cells, one per slot. a remove shifts every later
// occupied cell down by one from its upper neighbor, all cells in parallel.
// response path: append, remove and set pass the exec and done states; get
// also passes the read state for the two-stage registered or-tree read.
// the sequencer handles one request at a time: req_stall stays high outside
// the idle state, until the response of the current request is registered.
// reset clears the count and the handshake state; cell contents are not
// cleared and are only read below the count.
// a stalled response is held in the output register; the next request is
// still taken and executed, then waits until the response register frees.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store_unit import ils_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	state_t    state_q;
	state_t    state_nxt;
	req_t      req_q;
	cnt_t      count_q;
	cnt_t      count_nxt;
	rsp_t      res_q;
	rsp_t      res_nxt;
	logic      rd_sel_q;
	logic      is_get_ok;
	logic      in_range;
	logic      full;
	logic      out_free;
	logic      rsp_valid_q;
	rsp_t      rsp_q;
	cell_cmd_t cmd;
	logic      en_s1;
	logic      en_s2;
	item_t     cell_data [CAPACITY];
	item_t     cell_rd   [CAPACITY];
	item_t     rd_word;

	// request checks against the current count
	always_comb begin
		in_range  = (32'(req_q.index) < 32'(count_q));
		full      = (32'(count_q) >= 32'(CAPACITY));
		out_free  = !rsp_valid_q || !rsp_stall;
		is_get_ok = (req_q.req_type == REQ_GET) && in_range;
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = is_get_ok ? S_RD : S_DONE;
			end
			S_RD: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: cell command, count update and result fields
	always_comb begin
		req_stall         = (state_q != S_IDLE);
		en_s1             = 1'b0;
		en_s2             = (state_q == S_RD);
		count_nxt         = count_q;
		cmd.op            = CELL_NOP;
		cmd.pos           = idx_t'(req_q.index);
		cmd.last          = count_q - cnt_t'(1);
		cmd.data          = item_t'(req_q.item_data);
		res_nxt.read_data = '0;
		res_nxt.new_index = '0;
		res_nxt.status    = ST_OK;
		if (state_q == S_EXEC) begin
			en_s1 = 1'b1;
			case (req_q.req_type)
				REQ_APPEND: begin
					if (full) begin
						res_nxt.status = ST_FULL;
					end else begin
						cmd.op            = CELL_WRITE;
						cmd.pos           = idx_t'(count_q);
						res_nxt.new_index = 8'(count_q);
						count_nxt         = count_q + cnt_t'(1);
					end
				end
				REQ_REMOVE: begin
					if (!in_range) begin
						res_nxt.status = ST_RANGE;
					end else begin
						cmd.op    = CELL_SHIFT;
						count_nxt = count_q - cnt_t'(1);
					end
				end
				REQ_GET: begin
					if (!in_range) begin
						res_nxt.status = ST_RANGE;
					end else begin
						cmd.op = CELL_READ;
					end
				end
				REQ_SET: begin
					if (!in_range) begin
						res_nxt.status = ST_RANGE;
					end else begin
						cmd.op = CELL_WRITE;
					end
				end
				default: begin
					cmd.op = CELL_NOP;
				end
			endcase
		end
		res_nxt.entry_count = 9'(count_nxt);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, result staging and response register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_EXEC) begin
			res_q    <= res_nxt;
			rd_sel_q <= is_get_ok;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q.read_data   <= rd_sel_q ? 32'(rd_word) : 32'd0;
			rsp_q.new_index   <= res_q.new_index;
			rsp_q.entry_count <= res_q.entry_count;
			rsp_q.status      <= res_q.status;
		end
	end

	// row of entry cells, each fed by its upper neighbor, the top cell by zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		item_t nbr;
		if (i == CAPACITY - 1) begin : g_top
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[i + 1];
		end
		ils_cell u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.pos  (idx_t'(i)),
			.nbr  (nbr),
			.data (cell_data[i]),
			.rd   (cell_rd[i])
		);
	end

	ils_rd_tree u_rd_tree (
		.clk   (clk),
		.words (cell_rd),
		.en_s1 (en_s1),
		.en_s2 (en_s2),
		.rd    (rd_word)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(CAPACITY))
		else $error("count past capacity");

	// count only moves while a request executes
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EXEC |=> $stable(count_q))
		else $error("count changed outside execution");

	// an accepted append to a non-full store grows the count by one
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && req_q.req_type == REQ_APPEND && !full
		|=> count_q == $past(count_q) + cnt_t'(1))
		else $error("append did not grow count");

	// a failed request reports no data and no position
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK
		|-> rsp_q.read_data == 32'd0 && rsp_q.new_index == 8'd0)
		else $error("failed request carries payload");

	// a read only walks the tree for an in-range get
	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> $past(state_q) == S_EXEC && rd_sel_q)
		else $error("read stage without a valid get");

endmodule

`default_nettype wire

### tb/ils_store_checker.sv
`timescale 1ns / 1ps

module ils_store_checker import ils_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);

	// shadow copy of the list
	item_t       slots [CAPACITY];
	int unsigned level;
	rsp_t        due_rsp [$];
	int          err_cnt;

	initial begin
		level       = 0;
		err_cnt     = 0;
		mismatches  = 0;
		outstanding = 0;
	end

	// apply one request to the shadow list and return the response it should give
	function automatic rsp_t apply_to_list(input req_t r);
		rsp_t        o;
		int unsigned k;
		o = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_APPEND) begin
			if (level >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				slots[level] = r.item_data;
				o.new_index = 8'(level);
				level++;
			end
		end else if (r.index >= level) begin
			o.status = ST_RANGE;
		end else begin
			case (r.req_type)
				REQ_REMOVE: begin
					// close the gap: later occupied entries move down one
					for (k = r.index; k + 1 < level; k++)
						slots[k] = slots[k + 1];
					level--;
				end
				REQ_GET: begin
					o.read_data = slots[r.index];
				end
				default: begin
					slots[r.index] = r.item_data;
				end
			endcase
		end
		o.entry_count = 9'(level);
		return o;
	endfunction

	function automatic int field_bad(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// response beats first, so a beat never meets the request taken on the same edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					$display("%0t: response beat with nothing expected, actual %h",
						$time, rsp);
					err_cnt++;
				end else begin
					want = due_rsp.pop_front();
					err_cnt += field_bad("read_data", want.read_data, rsp.read_data);
					err_cnt += field_bad("new_index", 32'(want.new_index),
						32'(rsp.new_index));
					err_cnt += field_bad("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
					err_cnt += field_bad("status", 32'(want.status), 32'(rsp.status));
				end
			end
			if (req_valid && !req_stall)
				due_rsp.push_back(apply_to_list(req));
		end
		mismatches  <= err_cnt;
		outstanding <= due_rsp.size();
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ils_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int live_entries   = 0;
	bit growing        = 1'b1;

	indexed_list_store_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	ils_store_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one request beat, with random idle cycles ahead of it
	task automatic issue(input req_type_t kind, input logic [7:0] pos,
			input logic [31:0] value);
		req_t beat;
		beat.req_type  = kind;
		beat.index     = pos;
		beat.item_data = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		do @(posedge clk); while (req_stall);
		// rough count, only used to steer the random mix
		if (kind == REQ_APPEND && live_entries < CAPACITY)
			live_entries++;
		else if (kind == REQ_REMOVE && pos < live_entries)
			live_entries--;
	endtask

	// hold off until every response has come back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// random requests: long growing runs up to full, then shrinking runs down to empty
	task automatic random_run(input int n);
		int          roll;
		int          pick;
		req_type_t   kind;
		logic [7:0]  pos;
		logic [31:0] value;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (growing)
				kind = (roll < 80) ? REQ_APPEND : (roll < 85) ? REQ_REMOVE :
					(roll < 93) ? REQ_GET : REQ_SET;
			else
				kind = (roll < 10) ? REQ_APPEND : (roll < 70) ? REQ_REMOVE :
					(roll < 85) ? REQ_GET : REQ_SET;
			pick = $urandom_range(19);
			if (live_entries == 0 || pick < 2)
				pos = 8'($urandom_range(255));
			else if (pick == 2)
				pos = (live_entries > 255) ? 8'd255 : 8'(live_entries);
			else
				pos = 8'($urandom_range(live_entries - 1));
			pick = $urandom_range(15);
			value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
			issue(kind, pos, value);
			if (growing && live_entries == CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (!growing && live_entries == 0)
				growing = 1'b1;
		end
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 36;
		recv_stall_pct = 60;

		// empty list: every indexed request is out of range
		issue(REQ_GET,    8'd0,   32'h0);
		issue(REQ_REMOVE, 8'd0,   32'h0);
		issue(REQ_SET,    8'd255, 32'hffff_ffff);
		// a few entries with extreme values
		issue(REQ_APPEND, 8'd255, 32'h0000_0000);
		issue(REQ_APPEND, 8'd0,   32'hffff_ffff);
		issue(REQ_APPEND, 8'd0,   32'h5a5a_5a5a);
		issue(REQ_APPEND, 8'd0,   32'ha5a5_a5a5);
		issue(REQ_GET,    8'd0,   32'h0);
		issue(REQ_GET,    8'd1,   32'h0);
		issue(REQ_GET,    8'd3,   32'h0);
		issue(REQ_GET,    8'd4,   32'h0);
		issue(REQ_SET,    8'd2,   32'h1234_5678);
		issue(REQ_GET,    8'd2,   32'h0);
		// remove in the middle, at the end and at the front
		issue(REQ_REMOVE, 8'd1,   32'h0);
		issue(REQ_GET,    8'd1,   32'h0);
		issue(REQ_GET,    8'd2,   32'h0);
		issue(REQ_REMOVE, 8'd2,   32'h0);
		issue(REQ_GET,    8'd2,   32'h0);
		issue(REQ_REMOVE, 8'd0,   32'h0);
		issue(REQ_GET,    8'd0,   32'h0);
		issue(REQ_SET,    8'd0,   32'h0);
		issue(REQ_REMOVE, 8'd0,   32'h0);
		issue(REQ_REMOVE, 8'd255, 32'h0);
		issue(REQ_APPEND, 8'd128, 32'h8000_0001);

		// three idle patterns, each after a full drain of the response queue
		for (int p = 0; p < 3; p++) begin
			drain_responses();
			send_idle_pct  = (p == 0) ? 36 : (p == 1) ? 60 : 0;
			recv_stall_pct = (p == 0) ? 60 : (p == 1) ? 36 : 0;
			random_run(400);
		end

		req_valid <= 1'b0;
		n = 0;
		while (outstanding != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("** indexed_list_store_unit: PASSED **");
		else
			$display("** indexed_list_store_unit: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("** indexed_list_store_unit: FAILED **");
		$finish;
	end

endmodule

### indexed_list_store_unit.f
sv/ils_pkg.sv
sv/ils_cell.sv
sv/ils_rd_tree.sv
sv/indexed_list_store_unit.sv
tb/ils_store_checker.sv
tb/tb_top.sv
